// File: design/nfea_pkg.sv
// ----------------------------------------------------------------------------
// nfea_pkg: shared types and codes for the next-fit extent allocator
// Request and response items, status codes, register indexes and sequencer
// states.
// ----------------------------------------------------------------------------
`default_nettype none
package nfea_pkg;

   localparam int FIELD_BITS = 32;
   localparam int COUNT_BITS = 7;

   typedef enum logic {
      OP_ALLOC   = 1'b0,
      OP_RELEASE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_NOFIT = 2'd1,
      ST_ZERO  = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   localparam logic REG_ARENA_BASE   = 1'b0;
   localparam logic REG_ARENA_LENGTH = 1'b1;

   typedef struct packed {
      logic                  operation;
      logic [FIELD_BITS-1:0] request_size;
      logic [FIELD_BITS-1:0] release_address;
   } req_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] granted_address;
      logic [1:0]            status;
      logic [COUNT_BITS-1:0] free_extent_count;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_AREAD,
      S_ACHECK,
      S_FREAD,
      S_FCHECK,
      S_FDECIDE,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_WRITE,
      S_DONE
   } state_type;

endpackage : nfea_pkg
`default_nettype wire

// File: design/nfea_ram.sv
// ----------------------------------------------------------------------------
// nfea_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module nfea_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule : nfea_ram
`default_nettype wire

// File: design/next_fit_extent_allocator_top.sv
// ----------------------------------------------------------------------------
// next_fit_extent_allocator_top: next-fit free-extent allocator
// Address-ordered table of free extents with a roving next-fit pointer.
// ----------------------------------------------------------------------------
// A request item is taken when start is high and busy is low; busy then stays
// high until the response item appears on the rsp_ ports for exactly one cycle,
// marked by rsp_valid, which the receiver must take at once. Each table entry
// visited is read from the single table RAM and then compared. An allocate
// visits entries from the roving pointer onward, plus a shift (a read, then a
// write, per entry) when an extent empties. A release scans upward from the
// bottom of the table the same way, then shifts the upper part of the table by
// one entry when an extent is inserted or two extents join. Writing either
// arena register rebuilds the table as one extent (empty when the length is
// zero); the register writes are to be made only while the block is idle,
// and the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none
module next_fit_extent_allocator_top
   import nfea_pkg::*;
#(
   parameter int MAX_EXTENTS = 64,
   parameter int ADDR_BITS   = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire req_type               req_item,
   output logic                       rsp_valid,
   output rsp_type                    rsp_item,
   input  wire logic                  csr_wr_en,
   input  wire logic                  csr_index,
   input  wire logic [FIELD_BITS-1:0] csr_wr_data
);
   localparam int IDX_BITS = $clog2(MAX_EXTENTS);
   localparam int CNT_BITS = $clog2(MAX_EXTENTS + 1);
   localparam logic [ADDR_BITS-1:0] AMAX = '1;
   localparam logic [CNT_BITS-1:0]  CNT_FULL = CNT_BITS'(MAX_EXTENTS);

   typedef logic [ADDR_BITS-1:0] addr_type;
   typedef logic [CNT_BITS-1:0]  cnt_type;
   typedef logic [IDX_BITS-1:0]  idx_type;

   // The start and length of one extent live side by side in one RAM word.
   localparam int WORD_BITS = 2 * ADDR_BITS;

   state_type state_ff, state_in;
   cnt_type   count_ff, count_in;
   idx_type   rover_ff, rover_in;
   addr_type  base_ff, base_in, length_ff, length_in;
   logic      op_ff, op_in;
   addr_type  size_ff, size_in, raddr_ff, raddr_in;
   cnt_type   idx_ff, idx_in;     // scan or shift position
   cnt_type   steps_ff, steps_in; // entries visited by an allocate
   cnt_type   pos_ff, pos_in;     // insert / target position
   addr_type  prev_s_ff, prev_s_in, prev_l_ff, prev_l_in;
   logic      have_prev_ff, have_prev_in;
   addr_type  cur_s_ff, cur_s_in, cur_l_ff, cur_l_in;
   logic      have_cur_ff, have_cur_in;
   logic      shift_up_ff, shift_up_in; // 1: open a gap, 0: close one
   cnt_type   shift_end_ff, shift_end_in;
   addr_type  wr_s_ff, wr_s_in, wr_l_ff, wr_l_in;
   cnt_type   wr_pos_ff, wr_pos_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_ff, rsp_in;
   addr_type  grant_ff, grant_in;
   status_type stat_ff, stat_in;

   logic                 ram_we;
   idx_type              ram_wa, ram_ra;
   logic [WORD_BITS-1:0] ram_wd, ram_rd;
   addr_type             rd_s, rd_l;

   nfea_ram #(.WIDTH(WORD_BITS), .DEPTH(MAX_EXTENTS)) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   assign rd_s = ram_rd[WORD_BITS-1:ADDR_BITS];
   assign rd_l = ram_rd[ADDR_BITS-1:0];

   function automatic addr_type sat_add(addr_type a, addr_type b);
      logic [ADDR_BITS:0] s;
      begin
         s = {1'b0, a} + {1'b0, b};
         sat_add = s[ADDR_BITS] ? AMAX : s[ADDR_BITS-1:0];
      end
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rover_ff     <= '0;
         base_ff      <= '0;
         length_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rover_ff     <= rover_in;
         base_ff      <= base_in;
         length_ff    <= length_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      size_ff      <= size_in;
      raddr_ff     <= raddr_in;
      idx_ff       <= idx_in;
      steps_ff     <= steps_in;
      pos_ff       <= pos_in;
      prev_s_ff    <= prev_s_in;
      prev_l_ff    <= prev_l_in;
      have_prev_ff <= have_prev_in;
      cur_s_ff     <= cur_s_in;
      cur_l_ff     <= cur_l_in;
      have_cur_ff  <= have_cur_in;
      shift_up_ff  <= shift_up_in;
      shift_end_ff <= shift_end_in;
      wr_s_ff      <= wr_s_in;
      wr_l_ff      <= wr_l_in;
      wr_pos_ff    <= wr_pos_in;
      rsp_ff       <= rsp_in;
      grant_ff     <= grant_in;
      stat_ff      <= stat_in;
   end

   always_comb begin
      logic below, above;
      cnt_type  nxt;
      state_in     = state_ff;
      count_in     = count_ff;
      rover_in     = rover_ff;
      base_in      = base_ff;
      length_in    = length_ff;
      op_in        = op_ff;
      size_in      = size_ff;
      raddr_in     = raddr_ff;
      idx_in       = idx_ff;
      steps_in     = steps_ff;
      pos_in       = pos_ff;
      prev_s_in    = prev_s_ff;
      prev_l_in    = prev_l_ff;
      have_prev_in = have_prev_ff;
      cur_s_in     = cur_s_ff;
      cur_l_in     = cur_l_ff;
      have_cur_in  = have_cur_ff;
      shift_up_in  = shift_up_ff;
      shift_end_in = shift_end_ff;
      wr_s_in      = wr_s_ff;
      wr_l_in      = wr_l_ff;
      wr_pos_in    = wr_pos_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      grant_in     = grant_ff;
      stat_in      = stat_ff;
      ram_we       = 1'b0;
      ram_wa       = wr_pos_ff[IDX_BITS-1:0];
      ram_wd       = {wr_s_ff, wr_l_ff};
      ram_ra       = idx_ff[IDX_BITS-1:0];
      below        = 1'b0;
      above        = 1'b0;
      nxt          = idx_ff + 1'b1;
      busy         = (state_ff != S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = req_item.operation;
               size_in  = addr_type'(req_item.request_size);
               raddr_in = addr_type'(req_item.release_address);
               grant_in = '0;
               if (addr_type'(req_item.request_size) == '0) begin
                  stat_in  = ST_ZERO;
                  state_in = S_DONE;
               end else if (req_item.operation == OP_ALLOC) begin
                  if (count_ff == '0) begin
                     stat_in  = ST_NOFIT;
                     state_in = S_DONE;
                  end else begin
                     idx_in   = {{(CNT_BITS-IDX_BITS){1'b0}}, rover_ff};
                     steps_in = '0;
                     state_in = S_AREAD;
                  end
               end else begin
                  idx_in       = '0;
                  have_prev_in = 1'b0;
                  state_in     = S_FREAD;
               end
            end
         end
         S_AREAD: begin
            state_in = S_ACHECK; // RAM read in flight
         end
         S_ACHECK: begin
            cur_s_in = rd_s;
            cur_l_in = rd_l;
            if (rd_l >= size_ff) begin
               grant_in = rd_s;
               stat_in  = ST_OK;
               pos_in   = idx_ff;
               if (rd_l == size_ff) begin
                  // Extent empties: close the gap above it.
                  count_in = count_ff - 1'b1;
                  rover_in = (nxt >= count_ff) ? '0 : idx_ff[IDX_BITS-1:0];
                  shift_up_in  = 1'b0;
                  shift_end_in = count_ff - 1'b1;
                  if (nxt >= count_ff) begin
                     state_in = S_DONE;
                  end else begin
                     state_in = S_SHIFT_RD;
                     idx_in   = nxt;
                  end
               end else begin
                  wr_s_in   = rd_s + size_ff;
                  wr_l_in   = rd_l - size_ff;
                  wr_pos_in = idx_ff;
                  rover_in  = idx_ff[IDX_BITS-1:0];
                  state_in  = S_WRITE;
               end
            end else if (steps_ff + 1'b1 >= count_ff) begin
               stat_in  = ST_NOFIT;
               state_in = S_DONE;
            end else begin
               steps_in = steps_ff + 1'b1;
               idx_in   = (nxt >= count_ff) ? '0 : nxt;
               state_in = S_AREAD;
            end
         end
         S_FREAD: begin
            if (idx_ff >= count_ff) begin
               have_cur_in = 1'b0;
               state_in    = S_FDECIDE;
            end else begin
               state_in = S_FCHECK;
            end
         end
         S_FCHECK: begin
            if (rd_s <= raddr_ff) begin
               prev_s_in    = rd_s;
               prev_l_in    = rd_l;
               have_prev_in = 1'b1;
               idx_in       = nxt;
               state_in     = S_FREAD;
            end else begin
               cur_s_in    = rd_s;
               cur_l_in    = rd_l;
               have_cur_in = 1'b1;
               state_in    = S_FDECIDE;
            end
         end
         S_FDECIDE: begin
            // idx_ff is the first entry above the released block.
            below = have_prev_ff && ((prev_s_ff + prev_l_ff) == raddr_ff);
            above = have_cur_ff && ((raddr_ff + size_ff) == cur_s_ff);
            pos_in  = idx_ff;
            stat_in = ST_OK;
            if (below && above) begin
               wr_s_in   = prev_s_ff;
               wr_l_in   = sat_add(sat_add(prev_l_ff, size_ff), cur_l_ff);
               wr_pos_in = idx_ff - 1'b1;
               count_in  = count_ff - 1'b1;
               if (rover_ff == idx_ff[IDX_BITS-1:0] ||
                   {{(CNT_BITS-IDX_BITS){1'b0}}, rover_ff} > idx_ff) begin
                  rover_in = rover_ff - 1'b1;
               end
               shift_up_in  = 1'b0;
               shift_end_in = count_ff - 1'b1;
               if (nxt >= count_ff) begin
                  state_in = S_WRITE;
               end else begin
                  idx_in   = nxt;
                  state_in = S_SHIFT_RD;
               end
            end else if (below) begin
               wr_s_in   = prev_s_ff;
               wr_l_in   = sat_add(prev_l_ff, size_ff);
               wr_pos_in = idx_ff - 1'b1;
               state_in  = S_WRITE;
            end else if (above) begin
               wr_s_in   = raddr_ff;
               wr_l_in   = sat_add(cur_l_ff, size_ff);
               wr_pos_in = idx_ff;
               state_in  = S_WRITE;
            end else if (count_ff >= CNT_FULL) begin
               stat_in  = ST_FULL;
               state_in = S_DONE;
            end else begin
               wr_s_in   = raddr_ff;
               wr_l_in   = size_ff;
               wr_pos_in = idx_ff;
               if (count_ff == '0) begin
                  rover_in = '0;
               end else if ({{(CNT_BITS-IDX_BITS){1'b0}}, rover_ff} >= idx_ff) begin
                  rover_in = rover_ff + 1'b1;
               end
               count_in    = count_ff + 1'b1;
               shift_up_in = 1'b1;
               if (count_ff == idx_ff) begin
                  state_in = S_WRITE;
               end else begin
                  idx_in   = count_ff - 1'b1; // move entries up from the top
                  state_in = S_SHIFT_RD;
               end
            end
         end
         S_SHIFT_RD: begin
            state_in = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            ram_we = 1'b1;
            ram_wd = ram_rd;
            if (shift_up_ff) begin
               ram_wa = nxt[IDX_BITS-1:0];
               if (idx_ff == pos_ff) begin
                  state_in = S_WRITE;
               end else begin
                  idx_in   = idx_ff - 1'b1;
                  state_in = S_SHIFT_RD;
               end
            end else begin
               ram_wa = idx_ff[IDX_BITS-1:0] - 1'b1;
               if (idx_ff >= shift_end_ff) begin
                  // Allocate closes without a final write; a merge writes.
                  state_in = (op_ff == OP_ALLOC) ? S_DONE : S_WRITE;
               end else begin
                  idx_in   = nxt;
                  state_in = S_SHIFT_RD;
               end
            end
         end
         S_WRITE: begin
            ram_we   = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_in.granted_address = (stat_ff == ST_OK) ?
                                     FIELD_BITS'(grant_ff) : '0;
            rsp_in.status = stat_ff;
            rsp_in.free_extent_count = COUNT_BITS'(count_ff);
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A register write takes effect at once and rebuilds the table as a single
      // extent covering the arena (empty if the length is zero), so writes may come back to back.
      if (csr_wr_en) begin
         if (csr_index == REG_ARENA_BASE) begin
            base_in = addr_type'(csr_wr_data);
         end else begin
            length_in = addr_type'(csr_wr_data);
         end
         ram_we   = 1'b1;
         ram_wa   = '0;
         ram_wd   = {base_in, length_in};
         count_in = (length_in != '0) ? cnt_type'(1) : '0;
         rover_in = '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;
endmodule : next_fit_extent_allocator_top
`default_nettype wire

// File: design/nfea_checker.sv
// ----------------------------------------------------------------------------
// nfea_checker: port-level checks for the next-fit extent allocator
// Watches the request handshake and response ports over time.
// ----------------------------------------------------------------------------
`default_nettype none
module nfea_checker
   import nfea_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire logic    rsp_valid,
   input wire rsp_type rsp_item
);
   // An accepted item makes the block busy on the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted item did not raise busy");

   // A response is one cycle wide.
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response longer than one cycle");

   // A response comes only after the block was busy.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("response without work");

   // Failed requests grant no address.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status != ST_OK) |-> rsp_item.granted_address == '0)
      else $error("failed request granted an address");
endmodule : nfea_checker

bind next_fit_extent_allocator_top nfea_checker u_nfea_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
`default_nettype wire
